// File: sv/acbd_pkg.sv
package acbd_pkg;

  localparam int HALVES = 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_PEND0 = 2'd0,
    REG_PEND1 = 2'd1,
    REG_PEND2 = 2'd2,
    REG_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] row;
    logic [7:0]  code_first;
    logic [7:0]  code_second;
    logic [1:0]  set_index;
    logic        book_select;
    logic [7:0]  entry_index;
    logic [63:0] entry_low;
    logic [63:0] entry_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0] half_7;
    logic [15:0] half_6;
    logic [15:0] half_5;
    logic [15:0] half_4;
    logic [15:0] half_3;
    logic [15:0] half_2;
    logic [15:0] half_1;
    logic [15:0] half_0;
  } out_item_t;

  // Aligned operands after the first adder stage.
  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sub;
    logic        sign;
    logic [4:0]  exp;
    logic [13:0] big;
    logic [13:0] lesser;
    logic        zero_sign;
  } fa_align_t;

  // Raw sum after the second adder stage.
  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sign;
    logic [4:0]  exp;
    logic [14:0] sum;
    logic        zero_sign;
  } fa_sum_t;

endpackage

// File: sv/acbd_hadd.sv
// Three-stage binary16 adder, round to nearest even. Sums carry three extra bits
// (guard, round, sticky) below the 11-bit significand.
module acbd_hadd (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] y
);
  import acbd_pkg::*;

  fa_align_t al_r, al_nxt;
  fa_sum_t   sm_r, sm_nxt;
  logic [15:0] y_r, y_nxt;

  always_comb begin
    logic a_nan, b_nan, a_inf, b_inf, swap;
    logic [4:0] ea, eb, el, es;
    logic [10:0] ma, mb, ml, ms;
    logic [4:0] d;
    logic [26:0] ext;
    a_nan = (a[14:10] == 5'h1f) && (a[9:0] != 0);
    b_nan = (b[14:10] == 5'h1f) && (b[9:0] != 0);
    a_inf = a[14:0] == 15'h7c00;
    b_inf = b[14:0] == 15'h7c00;
    ea = (a[14:10] == 0) ? 5'd1 : a[14:10];
    eb = (b[14:10] == 0) ? 5'd1 : b[14:10];
    ma = {a[14:10] != 0, a[9:0]};
    mb = {b[14:10] != 0, b[9:0]};
    swap = {eb, mb} > {ea, ma};
    el = swap ? eb : ea;
    es = swap ? ea : eb;
    ml = swap ? mb : ma;
    ms = swap ? ma : mb;
    d = el - es;
    ext = {ms, 16'd0} >> d;
    al_nxt.special = a_nan || b_nan || a_inf || b_inf;
    if (a_nan) al_nxt.special_val = a | 16'h0200;
    else if (b_nan) al_nxt.special_val = b | 16'h0200;
    else if (a_inf && b_inf) al_nxt.special_val = (a[15] == b[15]) ? a : 16'h7e00;
    else if (a_inf) al_nxt.special_val = a;
    else al_nxt.special_val = b;
    al_nxt.sub = a[15] ^ b[15];
    al_nxt.sign = swap ? b[15] : a[15];
    al_nxt.exp = el;
    al_nxt.big = {ml, 3'b000};
    al_nxt.lesser = {ext[26:14], ext[13:0] != 0};
    al_nxt.zero_sign = a[15] & b[15];
  end

  always_comb begin
    sm_nxt.special = al_r.special;
    sm_nxt.special_val = al_r.special_val;
    sm_nxt.sign = al_r.sign;
    sm_nxt.exp = al_r.exp;
    sm_nxt.zero_sign = al_r.zero_sign;
    if (al_r.sub) sm_nxt.sum = {1'b0, al_r.big} - {1'b0, al_r.lesser};
    else sm_nxt.sum = {1'b0, al_r.big} + {1'b0, al_r.lesser};
  end

  // Normalize and round; the exponent is at least one, subnormals keep it.
  always_comb begin
    logic [3:0] lz;
    logic [5:0] e;
    logic [14:0] s;
    logic [13:0] n;
    logic [11:0] q;
    logic rnd;
    logic [6:0] ef;
    lz = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (sm_r.sum[i] && i <= 13) lz = 4'(13 - i);
    end
    s = sm_r.sum;
    if (s[14]) begin
      n = {s[14:2], s[1] | s[0]};
      e = {1'b0, sm_r.exp} + 6'd1;
    end else begin
      if ({2'b0, lz} >= {1'b0, sm_r.exp} - 6'd1) begin
        n = s[13:0] << (sm_r.exp - 5'd1);
        e = 6'd0;
      end else begin
        n = s[13:0] << lz;
        e = {1'b0, sm_r.exp} - {2'b0, lz};
      end
    end
    rnd = n[2] && (n[1] || n[0] || n[3]);
    q = {1'b0, n[13:3]} + {11'd0, rnd};
    // q overflowing into bit 11 or a subnormal becoming normal bumps the exponent.
    ef = {1'b0, e} + {6'd0, q[11]};
    if (e == 0 && q[10]) ef = 7'd1;
    if (sm_r.special) y_nxt = sm_r.special_val;
    else if (s == 0) y_nxt = {sm_r.zero_sign, 15'd0};
    else if (ef >= 7'd31) y_nxt = {sm_r.sign, 15'h7c00};
    else if (q[11]) y_nxt = {sm_r.sign, ef[4:0], q[10:1]};
    else y_nxt = {sm_r.sign, ef[4:0], q[9:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al_r <= al_nxt;
      sm_r <= sm_nxt;
      y_r <= y_nxt;
    end
  end

  assign y = y_r;
endmodule

// File: sv/acbd_books.sv
// Codebook store: two read ports (first and second book of the partition),
// one write port. Read data is registered; stage advances with en.
module acbd_books #(
  parameter int PARTITION_SETS = 4,
  parameter int BOOK_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         en,
  input  logic         wr_en,
  input  logic [1:0]   wr_set,
  input  logic         wr_book,
  input  logic [7:0]   wr_entry,
  input  logic [127:0] wr_data,
  input  logic [1:0]   rd_part,
  input  logic [7:0]   rd_code_a,
  input  logic [7:0]   rd_code_b,
  output logic [127:0] rd_a,
  output logic [127:0] rd_b
);
  localparam int DEPTH = PARTITION_SETS * BOOK_ENTRIES;
  localparam int AW = $clog2(DEPTH);

  logic [127:0] mem_a [DEPTH];
  logic [127:0] mem_b [DEPTH];
  logic [127:0] rd_a_r, rd_b_r;
  logic oor_a_r, oor_b_r;

  // A code beyond the book reads some other word; the flag below zeroes it.
  function automatic logic [AW-1:0] addr(input logic [1:0] s, input logic [7:0] e);
    return AW'(int'(s) * BOOK_ENTRIES + int'(e));
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en && int'(wr_set) < PARTITION_SETS && int'(wr_entry) < BOOK_ENTRIES) begin
      if (wr_book) mem_b[addr(wr_set, wr_entry)] <= wr_data;
      else mem_a[addr(wr_set, wr_entry)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_r <= mem_a[addr(rd_part, rd_code_a)];
      rd_b_r <= mem_b[addr(rd_part, rd_code_b)];
      oor_a_r <= int'(rd_code_a) >= BOOK_ENTRIES;
      oor_b_r <= int'(rd_code_b) >= BOOK_ENTRIES;
    end
  end

  assign rd_a = oor_a_r ? 128'd0 : rd_a_r;
  assign rd_b = oor_b_r ? 128'd0 : rd_b_r;
endmodule

// File: sv/additive_codebook_dequant_2x8_top.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | acbd_pkg::in_item_t
// out     | output    | out_valid/out_stall| acbd_pkg::out_item_t
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction enters per cycle while in_stall is low. A decode accepted with its row
// below the row limit raises out_valid after the partition select, codebook read and three
// adder stage registers. Loads write the store at the edge they are accepted and give no
// result. The whole pipeline freezes when the output is stalled with a valid result, so
// nothing is lost. Reset clears the valid bits and sets the configuration registers to all
// ones; codebook contents are undefined until loaded.
module additive_codebook_dequant_2x8_top #(
  parameter int PARTITION_SETS = 4,
  parameter int BOOK_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acbd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import acbd_pkg::*;

  logic [15:0] pend0_r, pend1_r, pend2_r, limit_r;
  logic [4:0] v_r;
  logic en;
  logic [1:0] part_r, part_nxt;
  logic [7:0] ca_r, cb_r;
  logic [127:0] rd_a, rd_b;
  logic [15:0] sums [HALVES];

  assign en = !(v_r[4] && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r <= 16'hffff;
      pend1_r <= 16'hffff;
      pend2_r <= 16'hffff;
      limit_r <= 16'hffff;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PEND0: pend0_r <= cfg_data;
        REG_PEND1: pend1_r <= cfg_data;
        REG_PEND2: pend2_r <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0] c;
    c = 2'(pend0_r <= in_data.row) + 2'(pend1_r <= in_data.row)
      + 2'(pend2_r <= in_data.row);
    if (int'(c) > PARTITION_SETS - 1) c = 2'(PARTITION_SETS - 1);
    part_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) begin
      v_r <= {v_r[3:0], in_valid && in_data.operation == OP_DECODE
                        && in_data.row < limit_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
      ca_r <= in_data.code_first;
      cb_r <= in_data.code_second;
    end
  end

  acbd_books #(.PARTITION_SETS(PARTITION_SETS), .BOOK_ENTRIES(BOOK_ENTRIES)) u_books (
    .clk(clk), .en(en),
    .wr_en(in_valid && en && in_data.operation == OP_LOAD),
    .wr_set(in_data.set_index), .wr_book(in_data.book_select),
    .wr_entry(in_data.entry_index),
    .wr_data({in_data.entry_high, in_data.entry_low}),
    .rd_part(part_r), .rd_code_a(ca_r), .rd_code_b(cb_r),
    .rd_a(rd_a), .rd_b(rd_b)
  );

  for (genvar k = 0; k < HALVES; k++) begin : g_add
    acbd_hadd u_add (
      .clk(clk), .en(en),
      .a(rd_a[16*k +: 16]), .b(rd_b[16*k +: 16]), .y(sums[k])
    );
  end

  assign out_valid = v_r[4];
  assign out_data = {sums[7], sums[6], sums[5], sums[4],
                     sums[3], sums[2], sums[1], sums[0]};
endmodule

// File: sv/acbd_checker.sv
module acbd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("spurious stall");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("cfg not ready");
endmodule

bind additive_codebook_dequant_2x8_top acbd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready)
);

// File: tb/tb.sv
module tb;
  import acbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = 4;
  localparam int ENTRIES = 256;
  localparam int DEPTH = SETS * 2 * ENTRIES;
  localparam int ITEM_W = $bits(in_item_t);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  additive_codebook_dequant_2x8_top #(
    .PARTITION_SETS(SETS),
    .BOOK_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state, updated at the edges where transactions complete.
  logic [63:0] book_lo[DEPTH];
  logic [63:0] book_hi[DEPTH];
  logic [15:0] bound_q[3];
  logic [15:0] limit_q;
  out_item_t   expected_sums[$];

  // Stimulus-side bookkeeping: which entries have been loaded, and the
  // configuration as the generator last wrote it.
  bit          loaded[DEPTH];
  int          loaded_codes[2 * SETS][$];
  logic [15:0] gen_bound[3];
  logic [15:0] gen_limit;
  in_item_t    pending_items[$];

  int  errors = 0;
  int  n_loads = 0;
  int  n_decodes = 0;
  int  n_checked = 0;
  bit  in_acc = 0;
  bit  out_acc = 0;
  bit  steady_in = 0;
  bit  steady_out = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  long_hold = 0;
  bit  long_hold_req = 0;
  bit  long_hold_done = 0;

  function automatic int partition_of(logic [15:0] row, logic [15:0] b0, logic [15:0] b1,
                                      logic [15:0] b2);
    int p;
    p = int'(b0 <= row) + int'(b1 <= row) + int'(b2 <= row);
    if (p > SETS - 1) p = SETS - 1;
    return p;
  endfunction

  function automatic logic [63:0] half_mag(logic [15:0] h);
    logic [63:0] m;
    m = {54'd0, h[9:0]};
    if (h[14:10] == 5'd0) return m;
    return (m | 64'h400) << (h[14:10] - 1);
  endfunction

  function automatic logic [15:0] round_mag(logic [63:0] mag);
    int          p;
    int          shift;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] halfway;
    logic [63:0] bits;
    if (mag < 64'h400) return mag[15:0];
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    shift = p - 10;
    if (shift == 0) return mag[15:0];
    q = mag >> shift;
    rem = mag & ((64'd1 << shift) - 1);
    halfway = 64'd1 << (shift - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    bits = (64'(shift) << 10) + q;
    if (bits >= 64'h7C00) bits = 64'h7C00;
    return bits[15:0];
  endfunction

  // Binary16 addition, round to nearest even, first NaN operand wins.
  function automatic logic [15:0] half_sum(logic [15:0] a, logic [15:0] b);
    bit          a_nan;
    bit          b_nan;
    bit          a_inf;
    bit          b_inf;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mag;
    logic        sign;
    a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 0);
    b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 0);
    a_inf = a[14:0] == 15'h7C00;
    b_inf = b[14:0] == 15'h7C00;
    if (a_nan) return a | 16'h0200;
    if (b_nan) return b | 16'h0200;
    if (a_inf && b_inf) return (a[15] == b[15]) ? a : 16'h7E00;
    if (a_inf) return a;
    if (b_inf) return b;
    ma = half_mag(a);
    mb = half_mag(b);
    if (a[15] == b[15]) begin
      mag = ma + mb;
      sign = a[15];
    end else if (ma >= mb) begin
      mag = ma - mb;
      sign = a[15];
    end else begin
      mag = mb - ma;
      sign = b[15];
    end
    if (mag == 0) return {a[15] & b[15], 15'd0};
    return {sign, 15'd0} | round_mag(mag);
  endfunction

  function automatic out_item_t predict_sum(in_item_t it);
    int          base;
    logic [63:0] la;
    logic [63:0] ua;
    logic [63:0] lb;
    logic [63:0] ub;
    logic [15:0] ha;
    logic [15:0] hb;
    logic [15:0] res[8];
    base = partition_of(it.row, bound_q[0], bound_q[1], bound_q[2]) * 2 * ENTRIES;
    la = book_lo[base + it.code_first];
    ua = book_hi[base + it.code_first];
    lb = book_lo[base + ENTRIES + it.code_second];
    ub = book_hi[base + ENTRIES + it.code_second];
    for (int k = 0; k < 8; k++) begin
      ha = (k < 4) ? la[(k % 4) * 16 +: 16] : ua[(k % 4) * 16 +: 16];
      hb = (k < 4) ? lb[(k % 4) * 16 +: 16] : ub[(k % 4) * 16 +: 16];
      res[k] = half_sum(ha, hb);
    end
    return {res[7], res[6], res[5], res[4], res[3], res[2], res[1], res[0]};
  endfunction

  function automatic logic [15:0] rand_half();
    logic [15:0] specials[10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7C01,
                                  16'hFE55, 16'h7BFF, 16'hFBFF, 16'h0001, 16'h83FF};
    case ($urandom_range(0, 5))
      0: return specials[$urandom_range(0, 9)];
      1: return {1'($urandom), 5'($urandom_range(0, 2)), 10'($urandom)};
      2: return {1'($urandom), 5'($urandom_range(27, 30)), 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  task automatic queue_load(int set, int book, int entry, logic [63:0] lo,
                            logic [63:0] hi);
    in_item_t it;
    int       addr;
    it = rand_fields();
    it.operation = OP_LOAD;
    it.set_index = 2'(set);
    it.book_select = 1'(book);
    it.entry_index = 8'(entry);
    it.entry_low = lo;
    it.entry_high = hi;
    addr = (set * 2 + book) * ENTRIES + entry;
    if (!loaded[addr]) begin
      loaded[addr] = 1;
      loaded_codes[set * 2 + book] = {loaded_codes[set * 2 + book], entry};
    end
    pending_items = {pending_items, it};
  endtask

  task automatic queue_decode(logic [15:0] row, logic [7:0] ca, logic [7:0] cb);
    in_item_t it;
    it = rand_fields();
    it.operation = OP_DECODE;
    it.row = row;
    it.code_first = ca;
    it.code_second = cb;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [63:0] rand_quad();
    return {rand_half(), rand_half(), rand_half(), rand_half()};
  endfunction

  // Generates one random transaction; decodes below the row limit only use loaded entries.
  task automatic queue_random();
    logic [15:0] row;
    int          p;
    int          book;
    if ($urandom_range(0, 9) < 3) begin
      queue_load($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 255),
                 rand_quad(), rand_quad());
      return;
    end
    case ($urandom_range(0, 9))
      7: row = gen_bound[$urandom_range(0, 2)] - 16'($urandom_range(0, 1));
      8, 9: row = 16'($urandom);
      default: row = (gen_limit == 0) ? 16'($urandom) : 16'($urandom_range(0, gen_limit - 1));
    endcase
    if (row >= gen_limit) begin
      queue_decode(row, 8'($urandom), 8'($urandom));
      return;
    end
    p = partition_of(row, gen_bound[0], gen_bound[1], gen_bound[2]);
    if (loaded_codes[2 * p].size() == 0 || loaded_codes[2 * p + 1].size() == 0) begin
      book = (loaded_codes[2 * p].size() == 0) ? 0 : 1;
      queue_load(p, book, $urandom_range(0, 255), rand_quad(), rand_quad());
      return;
    end
    queue_decode(row,
                 loaded_codes[2 * p][$urandom_range(0, loaded_codes[2 * p].size() - 1)],
                 loaded_codes[2 * p + 1][$urandom_range(0, loaded_codes[2 * p + 1].size() - 1)]);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LIMIT) gen_limit = value;
    else gen_bound[idx] = value;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
    // Loads finish silently, so give the pipeline its full depth before a register write.
    repeat (12) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Predictor: tracks accepted input and register transactions.
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) bound_q[i] = 16'hFFFF;
      limit_q = 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LIMIT) limit_q = cfg_data;
      else bound_q[cfg_index] = cfg_data;
    end
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.operation == OP_LOAD) begin
        n_loads++;
        book_lo[(in_data.set_index * 2 + in_data.book_select) * ENTRIES
                + in_data.entry_index] = in_data.entry_low;
        book_hi[(in_data.set_index * 2 + in_data.book_select) * ENTRIES
                + in_data.entry_index] = in_data.entry_high;
      end else begin
        n_decodes++;
        if (in_data.row < limit_q) expected_sums = {expected_sums, predict_sum(in_data)};
      end
    end
  end

  // Sender: one transaction at a time from the pending queue.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (in_valid && !in_acc) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
      gap_left <= steady_in ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold = 300;
      long_hold_done = 1;
    end
    if (out_acc) stall_left = steady_out ? 0 : $urandom_range(0, 4);
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compares each accepted result with the oldest expected sum.
  always @(posedge clk) begin
    out_item_t want;
    out_acc <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        n_checked++;
        for (int k = 0; k < 8; k++) begin
          if (want[k * 16 +: 16] !== out_data[k * 16 +: 16]) begin
            $error("half_%0d: expected %h, got %h", k, want[k * 16 +: 16],
                   out_data[k * 16 +: 16]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [63:0] ea_lo;
    logic [63:0] ea_hi;
    logic [63:0] eb_lo;
    logic [63:0] eb_hi;
    logic [15:0] phase_cfg[6][4];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PEND0;
    cfg_data = '0;
    for (int i = 0; i < 3; i++) begin
      gen_bound[i] = 16'hFFFF;
    end
    gen_limit = 16'hFFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Entry pairs that exercise NaN order, opposite and equal infinities, signed zeros,
    // overflow, subnormals and exact cancellation.
    ea_lo = {16'h8000, 16'h7C00, 16'h7C00, 16'h7C01};
    ea_hi = {16'h0000, 16'h3C00, 16'h03FF, 16'h7BFF};
    eb_lo = {16'h8000, 16'h7C00, 16'hFC00, 16'hFD00};
    eb_hi = {16'h8000, 16'hBC00, 16'h0001, 16'h7BFF};
    for (int s = 0; s < SETS; s++) begin
      queue_load(s, 0, 0, ea_lo, ea_hi);
      queue_load(s, 1, 0, eb_lo, eb_hi);
      queue_load(s, 0, 255, eb_lo, eb_hi);
      queue_load(s, 1, 255, ea_lo, ea_hi);
    end
    queue_decode(16'd0, 8'd0, 8'd0);
    queue_decode(16'd0, 8'd255, 8'd255);
    queue_decode(16'd65534, 8'd0, 8'd255);
    queue_decode(16'd65535, 8'd255, 8'd0);
    queue_load(0, 0, 17, {4{16'h7BFF}}, {4{16'hFBFF}});
    queue_load(0, 1, 17, {4{16'h0400}}, {4{16'h83FF}});
    queue_decode(16'h5AA5, 8'd17, 8'd17);
    drain();

    phase_cfg = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                  '{16'd100, 16'd200, 16'd300, 16'd400},
                  '{16'd300, 16'd100, 16'd0, 16'hFFFF},
                  '{16'd0, 16'd0, 16'd0, 16'd0},
                  '{16'd0, 16'd0, 16'd0, 16'hFFFF},
                  '{16'd1, 16'h8000, 16'hFFFE, 16'd1}};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PEND0, phase_cfg[ph][0]);
      write_reg(REG_PEND1, phase_cfg[ph][1]);
      write_reg(REG_PEND2, phase_cfg[ph][2]);
      write_reg(REG_LIMIT, phase_cfg[ph][3]);
      steady_in = (ph == 1);
      steady_out = (ph == 1 || ph == 4);
      repeat (215) queue_random();
      if (ph == 2) long_hold_req = 1;
      drain();
    end

    $display("%0d loads and %0d decodes sent, %0d sums checked over six register settings",
             n_loads, n_decodes, n_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
